// ----- hdl/sccb_pkg.sv -----
package sccb_pkg;

	// Bus sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_WBIT,
		PH_ACK,
		PH_STOP,
		PH_RBIT,
		PH_NOACK
	} phase_t;

	// Commands carried by a request.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Byte positions within a transaction.
	localparam logic [1:0] BYTE_ID    = 2'd0;
	localparam logic [1:0] BYTE_ADDR  = 2'd1;
	localparam logic [1:0] BYTE_THIRD = 2'd2;
	localparam logic [1:0] BYTE_READ  = 2'd3;

	// Slot counts: eight bits of two slots each, and the last start or stop slot.
	localparam logic [3:0] BIT_SLOT_LAST  = 4'd15;
	localparam logic [3:0] EDGE_SLOT_LAST = 4'd2;

	// Register reset value and the bit that turns a write id into a read id.
	localparam logic [7:0] DEV_ID_RESET = 8'd66;
	localparam logic [7:0] READ_ID_BIT  = 8'h01;

	// One result: line levels and status for one tick.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       drive;
		logic       busy;
		logic       done;
		logic       nack;
		logic [7:0] read_data;
	} result_t;

endpackage

// ----- hdl/sccb_seq.sv -----
module sccb_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                start_request,
	input  logic                command,
	input  logic [7:0]          register_address,
	input  logic [7:0]          write_data,
	input  logic                sda_in,
	input  logic                cfg_write,
	input  logic [7:0]          cfg_data,
	output sccb_pkg::result_t   result
);

	sccb_pkg::phase_t phase_q, phase_d;
	logic [3:0] bit_count_q, bit_count_d;
	logic [1:0] byte_index_q, byte_index_d;
	logic [7:0] shift_out_q, shift_out_d;
	logic [7:0] shift_in_q, shift_in_d;
	logic       nack_seen_q, nack_seen_d;
	logic       cmd_q, cmd_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] data_q, data_d;
	logic [7:0] dev_id_q;
	logic       slot;

	// Byte sent at a given position of the transaction.
	function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic cmd,
			input logic [7:0] id, input logic [7:0] addr, input logic [7:0] data);
		logic [7:0] b;
		if (idx == sccb_pkg::BYTE_ID) begin
			b = id;
		end else if (idx == sccb_pkg::BYTE_ADDR) begin
			b = addr;
		end else if (cmd == sccb_pkg::CMD_READ) begin
			b = id | sccb_pkg::READ_ID_BIT;
		end else begin
			b = data;
		end
		return b;
	endfunction

	// Device id register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q <= sccb_pkg::DEV_ID_RESET;
		end else if (cfg_write) begin
			dev_id_q <= cfg_data;
		end
	end

	// Sequencer state, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= sccb_pkg::PH_IDLE;
			bit_count_q  <= '0;
			byte_index_q <= '0;
			shift_out_q  <= '0;
			shift_in_q   <= '0;
			nack_seen_q  <= 1'b0;
			cmd_q        <= 1'b0;
			addr_q       <= '0;
			data_q       <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			byte_index_q <= byte_index_d;
			shift_out_q  <= shift_out_d;
			shift_in_q   <= shift_in_d;
			nack_seen_q  <= nack_seen_d;
			cmd_q        <= cmd_d;
			addr_q       <= addr_d;
			data_q       <= data_d;
		end
	end

	// Next state and line levels for the current tick.
	always_comb begin
		phase_d      = phase_q;
		bit_count_d  = bit_count_q;
		byte_index_d = byte_index_q;
		shift_out_d  = shift_out_q;
		shift_in_d   = shift_in_q;
		nack_seen_d  = nack_seen_q;
		cmd_d        = cmd_q;
		addr_d       = addr_q;
		data_d       = data_q;
		result       = '{scl: 1'b1, sda: 1'b1, drive: 1'b1, busy: 1'b1,
				done: 1'b0, nack: 1'b0, read_data: 8'd0};

		// An idle tick either stays idle or latches a new request.
		if (phase_q == sccb_pkg::PH_IDLE) begin
			if (!start_request) begin
				result.busy = 1'b0;
			end else begin
				cmd_d        = command;
				addr_d       = register_address;
				data_d       = write_data;
				byte_index_d = sccb_pkg::BYTE_ID;
				nack_seen_d  = 1'b0;
				shift_in_d   = '0;
				phase_d      = sccb_pkg::PH_START;
				bit_count_d  = '0;
			end
		end

		slot = bit_count_d[0];
		unique case (phase_d)
			sccb_pkg::PH_START: begin
				result.scl = (bit_count_d < sccb_pkg::EDGE_SLOT_LAST);
				result.sda = (bit_count_d == 4'd0);
				if (bit_count_d >= sccb_pkg::EDGE_SLOT_LAST) begin
					phase_d     = sccb_pkg::PH_WBIT;
					bit_count_d = '0;
					shift_out_d = byte_for(byte_index_d, cmd_d, dev_id_q, addr_d, data_d);
				end else begin
					bit_count_d = bit_count_d + 4'd1;
				end
			end
			sccb_pkg::PH_WBIT: begin
				result.scl = slot;
				result.sda = shift_out_d[7];
				if (slot) begin
					shift_out_d = {shift_out_d[6:0], 1'b0};
				end
				if (bit_count_d == sccb_pkg::BIT_SLOT_LAST) begin
					phase_d     = sccb_pkg::PH_ACK;
					bit_count_d = '0;
				end else begin
					bit_count_d = bit_count_d + 4'd1;
				end
			end
			sccb_pkg::PH_ACK: begin
				result.drive = 1'b0;
				result.scl   = slot;
				if (!slot) begin
					bit_count_d = 4'd1;
				end else begin
					if (sda_in) begin
						nack_seen_d = 1'b1;
					end
					if (cmd_d == sccb_pkg::CMD_READ && byte_index_d == sccb_pkg::BYTE_THIRD) begin
						phase_d      = sccb_pkg::PH_RBIT;
						bit_count_d  = '0;
						byte_index_d = sccb_pkg::BYTE_READ;
						shift_in_d   = '0;
					end else if ((cmd_d == sccb_pkg::CMD_WRITE &&
							byte_index_d == sccb_pkg::BYTE_THIRD) ||
							(cmd_d == sccb_pkg::CMD_READ &&
							byte_index_d == sccb_pkg::BYTE_ADDR)) begin
						phase_d     = sccb_pkg::PH_STOP;
						bit_count_d = '0;
					end else begin
						byte_index_d = byte_index_d + 2'd1;
						phase_d      = sccb_pkg::PH_WBIT;
						bit_count_d  = '0;
						shift_out_d  = byte_for(byte_index_d, cmd_d, dev_id_q, addr_d, data_d);
					end
				end
			end
			sccb_pkg::PH_STOP: begin
				result.scl = (bit_count_d != 4'd0);
				result.sda = (bit_count_d >= sccb_pkg::EDGE_SLOT_LAST);
				if (bit_count_d >= sccb_pkg::EDGE_SLOT_LAST) begin
					if (cmd_d == sccb_pkg::CMD_WRITE || byte_index_d == sccb_pkg::BYTE_READ) begin
						result.done = 1'b1;
						if (cmd_d == sccb_pkg::CMD_READ) begin
							result.read_data = shift_in_d;
						end else begin
							result.nack = nack_seen_d;
						end
						phase_d     = sccb_pkg::PH_IDLE;
						bit_count_d = '0;
					end else begin
						// Repeated start for the read half.
						byte_index_d = sccb_pkg::BYTE_THIRD;
						phase_d      = sccb_pkg::PH_START;
						bit_count_d  = '0;
					end
				end else begin
					bit_count_d = bit_count_d + 4'd1;
				end
			end
			sccb_pkg::PH_RBIT: begin
				result.drive = 1'b0;
				result.scl   = slot;
				if (slot) begin
					shift_in_d = {shift_in_d[6:0], sda_in};
				end
				if (bit_count_d == sccb_pkg::BIT_SLOT_LAST) begin
					phase_d     = sccb_pkg::PH_NOACK;
					bit_count_d = '0;
				end else begin
					bit_count_d = bit_count_d + 4'd1;
				end
			end
			sccb_pkg::PH_NOACK: begin
				result.scl = slot;
				result.sda = 1'b1;
				if (slot) begin
					phase_d     = sccb_pkg::PH_STOP;
					bit_count_d = '0;
				end else begin
					bit_count_d = 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// The bit counter is always cleared while idle.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sccb_pkg::PH_IDLE |-> bit_count_q == 4'd0)
		else $error("bit counter not cleared in idle");

	// A finishing tick is always part of a transaction.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.done |-> result.busy)
		else $error("done without busy");

	// Nack and read data never come from the same transaction.
	a_nack_read: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.nack |-> result.read_data == 8'd0)
		else $error("nack reported on a read");

	// The data line is released only while a transaction runs.
	a_release_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && !result.drive |-> result.busy && phase_q != sccb_pkg::PH_IDLE)
		else $error("data line released while idle");

endmodule

// ----- hdl/sccb_outbuf.sv -----
module sccb_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sccb_pkg::result_t   push_data,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output sccb_pkg::result_t   out_data
);

	sccb_pkg::result_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rd_ptr_q];

	// Two-entry result store.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The fill count never exceeds the depth.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	// A result is never stored into a full buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != 2'd2)
		else $error("result buffer overflow");

	// Pointers differ exactly when the buffer holds one entry.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q != rd_ptr_q) == (count_q == 2'd1))
		else $error("result buffer pointers disagree with count");

endmodule

// ----- hdl/sccb_register_master.sv -----
// Chan  Handshake            Fields
// in    in_valid/in_ready    start_request, command, register_address, write_data, sda_in
// out   out_valid/out_ready  scl_level, sda_level, sda_drive, busy_res, done_res, nack, read_data
// cfg   cfg_valid/cfg_ready  cfg_data (device write id)
//
// Each request is one bus tick, taken every cycle in_ready is set, and yields exactly one result.
// The sequencer state advances in the same cycle a request is accepted; the result lands in a
// two-entry buffer, so in_ready depends only on that buffer's fill count.
// A stalled output holds up to two results; in_ready drops only when both are waiting.
// Reset puts the sequencer in idle and sets the device write id to 66. The configuration port
// is always ready; the user must write it only while idle, which the block does not enforce.
module sccb_register_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       start_request,
	input  logic       command,
	input  logic [7:0] register_address,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic       nack,
	output logic [7:0] read_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	sccb_pkg::result_t step_result;
	sccb_pkg::result_t out_result;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// Bus sequencer.
	sccb_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (accept),
		.start_request    (start_request),
		.command          (command),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.cfg_write        (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.result           (step_result)
	);

	// Result buffer between the sequencer and the output channel.
	sccb_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_result),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_result)
	);

	assign scl_level = out_result.scl;
	assign sda_level = out_result.sda;
	assign sda_drive = out_result.drive;
	assign busy_res  = out_result.busy;
	assign done_res  = out_result.done;
	assign nack      = out_result.nack;
	assign read_data = out_result.read_data;

endmodule
